// File: design/fsc_pkg.sv
package fsc_pkg;

    typedef enum logic [3:0] {
        OP_START         = 4'd0,
        OP_CONFIRM       = 4'd1,
        OP_CANCEL_ARMING = 4'd2,
        OP_STOP          = 4'd3,
        OP_STOP_SESSION  = 4'd4,
        OP_PREEMPT       = 4'd5,
        OP_POLL          = 4'd6,
        OP_ACK_UI        = 4'd7,
        OP_ACK_EVENT     = 4'd8
    } op_t;

    typedef enum logic [3:0] {
        RC_ACCEPTED      = 4'd0,
        RC_ALREADY       = 4'd1,
        RC_BUSY_ALARM    = 4'd2,
        RC_BUSY_TRANSFER = 4'd3,
        RC_RATE_LIMIT    = 4'd4,
        RC_STOPPING      = 4'd5,
        RC_IDLE          = 4'd6,
        RC_STALE         = 4'd7,
        RC_INVALID       = 4'd8,
        RC_NONE          = 4'd9
    } rc_t;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_ARMING   = 2'd1,
        PH_ACTIVE   = 2'd2,
        PH_STOPPING = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ER_NONE    = 3'd0,
        ER_USER    = 3'd1,
        ER_PHONE   = 3'd2,
        ER_TIMEOUT = 3'd3,
        ER_PREEMPT = 3'd4
    } er_t;

    localparam logic [1:0] T_ACCEPTED  = 2'd0;
    localparam logic [1:0] T_DUPLICATE = 2'd1;
    localparam logic [1:0] T_BUSY      = 2'd2;
    localparam logic [1:0] T_STOP      = 2'd3;

    localparam logic [31:0] WORD_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [3:0]  operation;
        logic [15:0] request_id;
        logic [31:0] now_tick;
        logic [31:0] duration_ticks;
        logic [31:0] cooldown_ticks;
        logic        alarm_busy;
        logic        transfer_busy;
        logic [2:0]  stop_reason;
    } event_t;

    typedef struct packed {
        phase_t          phase;
        logic [2:0]      reason_now;
        logic [15:0]     session_now;
        logic [31:0]     start_time;
        logic [31:0]     length_now;
        logic [31:0]     cooldown_now;
        logic [15:0]     last_done_session;
        logic            has_done;
        logic [31:0]     last_end_time;
        logic            pending_flag;
        logic [15:0]     pending_session;
        logic [2:0]      pending_reason;
        logic [31:0]     change_count;
        logic [3:0][31:0] tallies;
    } state_t;

    typedef struct packed {
        logic [3:0]  result_code;
        logic        granted;
        logic [1:0]  session_state;
        logic [2:0]  end_reason;
        logic [15:0] current_session;
        logic [31:0] generation;
        logic [31:0] accepted_count;
        logic [31:0] duplicate_count;
        logic [31:0] busy_count;
        logic [31:0] stop_count;
        logic [15:0] event_session;
        logic [2:0]  event_reason;
    } result_t;

endpackage

// File: design/fsc_event_if.sv
interface fsc_event_if;
    logic        valid;
    logic        ready;
    logic [3:0]  operation;
    logic [15:0] request_id;
    logic [31:0] now_tick;
    logic [31:0] duration_ticks;
    logic [31:0] cooldown_ticks;
    logic        alarm_busy;
    logic        transfer_busy;
    logic [2:0]  stop_reason;

    modport source (
        output valid, operation, request_id, now_tick, duration_ticks,
               cooldown_ticks, alarm_busy, transfer_busy, stop_reason,
        input  ready
    );

    modport sink (
        input  valid, operation, request_id, now_tick, duration_ticks,
               cooldown_ticks, alarm_busy, transfer_busy, stop_reason,
        output ready
    );
endinterface

// File: design/fsc_result_if.sv
interface fsc_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  result_code;
    logic        granted;
    logic [1:0]  session_state;
    logic [2:0]  end_reason;
    logic [15:0] current_session;
    logic [31:0] generation;
    logic [31:0] accepted_count;
    logic [31:0] duplicate_count;
    logic [31:0] busy_count;
    logic [31:0] stop_count;
    logic [15:0] event_session;
    logic [2:0]  event_reason;

    modport source (
        output valid, result_code, granted, session_state, end_reason,
               current_session, generation, accepted_count, duplicate_count,
               busy_count, stop_count, event_session, event_reason,
        input  ready
    );

    modport sink (
        input  valid, result_code, granted, session_state, end_reason,
               current_session, generation, accepted_count, duplicate_count,
               busy_count, stop_count, event_session, event_reason,
        output ready
    );
endinterface

// File: design/fsc_event_logic.sv
module fsc_event_logic
(
    input  fsc_pkg::state_t  state,
    input  fsc_pkg::event_t  ev,
    output fsc_pkg::state_t  state_next,
    output fsc_pkg::result_t result
);

    // Saturating tally bump.
    function automatic fsc_pkg::state_t bump(fsc_pkg::state_t s, logic [1:0] which);
        fsc_pkg::state_t r;
        r = s;
        if (s.tallies[which] != fsc_pkg::WORD_MAX)
        begin
            r.tallies[which] = s.tallies[which] + 32'd1;
        end
        return r;
    endfunction

    // Move an arming or active session into stopping.
    function automatic fsc_pkg::state_t enter_stop(fsc_pkg::state_t s, logic [2:0] why);
        fsc_pkg::state_t r;
        r = s;
        if (s.phase == fsc_pkg::PH_ACTIVE || s.phase == fsc_pkg::PH_ARMING)
        begin
            r.phase        = fsc_pkg::PH_STOPPING;
            r.reason_now   = why;
            r.change_count = s.change_count + 32'd1;
            r              = bump(r, fsc_pkg::T_STOP);
        end
        return r;
    endfunction

    fsc_pkg::state_t st;
    fsc_pkg::rc_t    rc;
    logic            grant;
    logic            reason_ok;
    logic            live;
    logic [31:0]     since_end;
    logic [31:0]     since_start;

    assign reason_ok   = (ev.stop_reason == fsc_pkg::ER_USER) ||
                         (ev.stop_reason == fsc_pkg::ER_PHONE);
    assign live        = (state.phase == fsc_pkg::PH_ACTIVE) ||
                         (state.phase == fsc_pkg::PH_ARMING);
    assign since_end   = ev.now_tick - state.last_end_time;
    assign since_start = ev.now_tick - state.start_time;

    always_comb
    begin
        st    = state;
        rc    = fsc_pkg::RC_NONE;
        grant = 1'b0;
        unique case (ev.operation) inside
            fsc_pkg::OP_START:
            begin
                if (ev.request_id == 16'd0 || ev.duration_ticks == 32'd0)
                begin
                    rc = fsc_pkg::RC_INVALID;
                end
                else if (live)
                begin
                    if (ev.request_id == state.session_now)
                    begin
                        st = bump(st, fsc_pkg::T_DUPLICATE);
                        rc = fsc_pkg::RC_ACCEPTED;
                    end
                    else
                    begin
                        rc = fsc_pkg::RC_ALREADY;
                    end
                end
                else if (state.phase == fsc_pkg::PH_STOPPING)
                begin
                    rc = fsc_pkg::RC_ALREADY;
                end
                else if (state.has_done && ev.request_id == state.last_done_session)
                begin
                    st = bump(st, fsc_pkg::T_DUPLICATE);
                    rc = fsc_pkg::RC_STALE;
                end
                else if (state.pending_flag)
                begin
                    rc = fsc_pkg::RC_RATE_LIMIT;
                end
                else if (ev.alarm_busy)
                begin
                    st = bump(st, fsc_pkg::T_BUSY);
                    rc = fsc_pkg::RC_BUSY_ALARM;
                end
                else if (ev.transfer_busy)
                begin
                    st = bump(st, fsc_pkg::T_BUSY);
                    rc = fsc_pkg::RC_BUSY_TRANSFER;
                end
                else if (state.has_done && since_end < state.cooldown_now)
                begin
                    rc = fsc_pkg::RC_RATE_LIMIT;
                end
                else
                begin
                    st.phase        = fsc_pkg::PH_ARMING;
                    st.reason_now   = fsc_pkg::ER_NONE;
                    st.session_now  = ev.request_id;
                    st.start_time   = ev.now_tick;
                    st.length_now   = ev.duration_ticks;
                    st.cooldown_now = ev.cooldown_ticks;
                    st.change_count = state.change_count + 32'd1;
                    st              = bump(st, fsc_pkg::T_ACCEPTED);
                    grant           = 1'b1;
                    rc              = fsc_pkg::RC_ACCEPTED;
                end
            end
            fsc_pkg::OP_CONFIRM:
            begin
                if (state.phase == fsc_pkg::PH_ARMING && ev.request_id == state.session_now)
                begin
                    st.phase        = fsc_pkg::PH_ACTIVE;
                    st.change_count = state.change_count + 32'd1;
                    grant           = 1'b1;
                end
            end
            fsc_pkg::OP_CANCEL_ARMING:
            begin
                if (state.phase == fsc_pkg::PH_ARMING && ev.request_id == state.session_now)
                begin
                    st.phase        = fsc_pkg::PH_IDLE;
                    st.reason_now   = fsc_pkg::ER_NONE;
                    st.session_now  = 16'd0;
                    st.start_time   = 32'd0;
                    st.length_now   = 32'd0;
                    st.change_count = state.change_count + 32'd1;
                end
            end
            fsc_pkg::OP_STOP, fsc_pkg::OP_STOP_SESSION:
            begin
                if (ev.operation == fsc_pkg::OP_STOP_SESSION && ev.request_id == 16'd0)
                begin
                    rc = fsc_pkg::RC_INVALID;
                end
                else if (ev.operation == fsc_pkg::OP_STOP_SESSION &&
                         (state.phase == fsc_pkg::PH_ACTIVE ||
                          state.phase == fsc_pkg::PH_STOPPING) &&
                         ev.request_id != state.session_now)
                begin
                    rc = fsc_pkg::RC_STALE;
                end
                else if (!reason_ok)
                begin
                    rc = fsc_pkg::RC_INVALID;
                end
                else if (state.phase == fsc_pkg::PH_ACTIVE)
                begin
                    st = enter_stop(st, ev.stop_reason);
                    rc = fsc_pkg::RC_STOPPING;
                end
                else if (state.phase == fsc_pkg::PH_STOPPING)
                begin
                    rc = fsc_pkg::RC_STOPPING;
                end
                else
                begin
                    rc = fsc_pkg::RC_IDLE;
                end
            end
            fsc_pkg::OP_PREEMPT:
            begin
                st = enter_stop(st, fsc_pkg::ER_PREEMPT);
            end
            fsc_pkg::OP_POLL:
            begin
                if (state.phase == fsc_pkg::PH_ACTIVE && since_start >= state.length_now)
                begin
                    st = enter_stop(st, fsc_pkg::ER_TIMEOUT);
                end
            end
            fsc_pkg::OP_ACK_UI:
            begin
                if (state.phase == fsc_pkg::PH_STOPPING)
                begin
                    st.pending_session   = state.session_now;
                    st.pending_reason    = state.reason_now;
                    st.pending_flag      = 1'b1;
                    st.last_done_session = state.session_now;
                    st.has_done          = 1'b1;
                    st.last_end_time     = ev.now_tick;
                    st.phase             = fsc_pkg::PH_IDLE;
                    st.session_now       = 16'd0;
                    st.start_time        = 32'd0;
                    st.length_now        = 32'd0;
                    st.change_count      = state.change_count + 32'd1;
                    grant                = 1'b1;
                end
            end
            fsc_pkg::OP_ACK_EVENT:
            begin
                st.pending_flag = 1'b0;
            end
            default:
            begin
                st = state;
            end
        endcase
    end

    assign state_next = st;

    always_comb
    begin
        result.result_code     = rc;
        result.granted         = grant;
        result.session_state   = st.phase;
        result.end_reason      = st.reason_now;
        result.current_session = st.session_now;
        result.generation      = st.change_count;
        result.accepted_count  = st.tallies[fsc_pkg::T_ACCEPTED];
        result.duplicate_count = st.tallies[fsc_pkg::T_DUPLICATE];
        result.busy_count      = st.tallies[fsc_pkg::T_BUSY];
        result.stop_count      = st.tallies[fsc_pkg::T_STOP];
        result.event_session   = st.pending_flag ? st.pending_session : 16'd0;
        result.event_reason    = st.pending_flag ? st.pending_reason : 3'd0;
    end

endmodule

// File: design/find_session_controller_core.sv
// Session controller core. Each item on "events" is one controller event
// (start, confirm, cancel arming, stop, stop for a session, alarm preempt,
// timeout poll, UI stopped acknowledge, end-event acknowledge) and yields
// exactly one item on "results": the outcome code, the grant flag and a
// snapshot of phase, current session, generation, the four saturating
// tallies and the pending end event as they stand after that event.
// An event is captured in an input register, evaluated by one pass of
// compare and 32-bit subtract logic against the controller state, and the
// outcome lands in the result register in the same edge that updates the
// state. The result is presented from the result register, so an accepted
// event passes through the input register and then the result register;
// one event per cycle is sustained while the result side keeps taking items.
// The input register takes a new event while the previous result waits;
// once both registers are full, a stall on the result side holds the event
// side as well.
// Reset clears the controller to idle with all counters at zero.
module find_session_controller_core
(
    input  logic                clk,
    input  logic                rst_n,
    fsc_event_if.sink           events,
    fsc_result_if.source        results
);

    // Input stage: captured event waiting for evaluation.
    fsc_pkg::event_t  ev_reg;
    fsc_pkg::event_t  ev_next;
    logic             ev_valid_reg;
    logic             ev_valid_next;

    // Controller state, updated as each event is evaluated.
    fsc_pkg::state_t  state_reg;
    fsc_pkg::state_t  state_next;

    // Output stage: result waiting for the consumer.
    fsc_pkg::result_t res_reg;
    fsc_pkg::result_t res_next;
    logic             res_valid_reg;
    logic             res_valid_next;

    fsc_pkg::state_t  eval_state;
    fsc_pkg::result_t eval_result;
    logic             advance;
    logic             take_in;

    fsc_event_logic u_logic
    (
        .state      (state_reg),
        .ev         (ev_reg),
        .state_next (eval_state),
        .result     (eval_result)
    );

    // Evaluate the held event when the result register is free or drains now.
    assign advance      = ev_valid_reg && (!res_valid_reg || results.ready);
    assign events.ready = !ev_valid_reg || advance;
    assign take_in      = events.valid && events.ready;

    always_comb
    begin
        ev_next       = ev_reg;
        ev_valid_next = ev_valid_reg;
        if (take_in)
        begin
            ev_next.operation      = events.operation;
            ev_next.request_id     = events.request_id;
            ev_next.now_tick       = events.now_tick;
            ev_next.duration_ticks = events.duration_ticks;
            ev_next.cooldown_ticks = events.cooldown_ticks;
            ev_next.alarm_busy     = events.alarm_busy;
            ev_next.transfer_busy  = events.transfer_busy;
            ev_next.stop_reason    = events.stop_reason;
            ev_valid_next          = 1'b1;
        end
        else if (advance)
        begin
            ev_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            state_next     = eval_state;
            res_next       = eval_result;
            res_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            // Drop the delivered result.
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            ev_valid_reg  <= ev_valid_next;
            res_valid_reg <= res_valid_next;
            state_reg     <= state_next;
        end
    end

    // Payload registers hold without reset.
    always_ff @(posedge clk)
    begin
        ev_reg  <= ev_next;
        res_reg <= res_next;
    end

    assign results.valid           = res_valid_reg;
    assign results.result_code     = res_reg.result_code;
    assign results.granted         = res_reg.granted;
    assign results.session_state   = res_reg.session_state;
    assign results.end_reason      = res_reg.end_reason;
    assign results.current_session = res_reg.current_session;
    assign results.generation      = res_reg.generation;
    assign results.accepted_count  = res_reg.accepted_count;
    assign results.duplicate_count = res_reg.duplicate_count;
    assign results.busy_count      = res_reg.busy_count;
    assign results.stop_count      = res_reg.stop_count;
    assign results.event_session   = res_reg.event_session;
    assign results.event_reason    = res_reg.event_reason;

endmodule
